// ----- rtl/nlp_pkg.sv -----
// shared types and character constants for the numeric literal parser
package nlp_pkg;

  typedef enum logic [7:0] {
    MODE_START = 8'b0000_0001,
    MODE_DEC   = 8'b0000_0010,
    MODE_OCTN  = 8'b0000_0100,
    MODE_HEX   = 8'b0000_1000,
    MODE_QUOTE = 8'b0001_0000,
    MODE_ESC   = 8'b0010_0000,
    MODE_OCTE  = 8'b0100_0000,
    MODE_ENDED = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [31:0] acc;
    mode_t       mode;
    logic [1:0]  pos;
    logic        stopped;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{acc: 32'd0, mode: MODE_START, pos: 2'd0,
                                           stopped: 1'b0};

  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_DQUOTE    = 8'd34;
  localparam logic [7:0] CH_QUOTE     = 8'd39;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_ONE       = 8'd49;
  localparam logic [7:0] CH_SEVEN     = 8'd55;
  localparam logic [7:0] CH_NINE      = 8'd57;
  localparam logic [7:0] CH_QMARK     = 8'd63;
  localparam logic [7:0] CH_UPPER_A   = 8'd65;
  localparam logic [7:0] CH_UPPER_F   = 8'd70;
  localparam logic [7:0] CH_UPPER_X   = 8'd88;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_LOWER_A   = 8'd97;
  localparam logic [7:0] CH_LOWER_F   = 8'd102;
  localparam logic [7:0] CH_LOWER_N   = 8'd110;
  localparam logic [7:0] CH_LOWER_R   = 8'd114;
  localparam logic [7:0] CH_LOWER_T   = 8'd116;
  localparam logic [7:0] CH_LOWER_V   = 8'd118;
  localparam logic [7:0] CH_LOWER_X   = 8'd120;

  localparam logic [31:0] VAL_NEWLINE   = 32'd10;
  localparam logic [31:0] VAL_TAB       = 32'd9;
  localparam logic [31:0] VAL_VTAB      = 32'd11;
  localparam logic [31:0] VAL_RETURN    = 32'd13;
  localparam logic [31:0] VAL_BACKSLASH = 32'd92;

endpackage

// ----- rtl/numeric_literal_parser_core.sv -----
// top level of the C integer and character literal parser
//
//  channel | dir | tdata                 | tlast        | tuser
//  in_     | in  | [7:0] char_code       | end_of_token | -
//  out_    | out | [31:0] literal_value  | -            | -
//
// one character word accepted per cycle while no waiting result stalls in_; the parse state updates in the same
// cycle through a single combinational step stage
// the token value appears on out_ in the cycle after its last word is accepted
// reset clears the parse state and the output valid flag, not the output data register
// a waiting result stalls in_ only until out_tready takes it
module numeric_literal_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] literal_value
);
  import nlp_pkg::*;

  parse_state_t st_r;
  parse_state_t st_nxt;
  logic [31:0]  value;
  logic [31:0]  out_data_r;
  logic         out_valid_r;
  logic         in_fire;

  nlp_step u_step (
    .st        (st_r),
    .char_code (in_tdata),
    .st_nxt    (st_nxt),
    .value     (value)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= in_tlast ? STATE_RESET : st_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_fire && in_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_data_r <= value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/nlp_step.sv -----
// next-state and token value logic for one character
module nlp_step (
  input  nlp_pkg::parse_state_t st,
  input  logic [7:0]            char_code,
  output nlp_pkg::parse_state_t st_nxt,
  output logic [31:0]           value
);
  import nlp_pkg::*;

  logic        is_oct;
  logic        is_dec;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [31:0] digit;
  logic [31:0] acc_x10;

  always_comb begin
    is_oct  = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
    is_dec  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_hex  = 1'b1;
    hex_val = '0;
    if (is_dec) begin
      hex_val = 4'(char_code - CH_ZERO);
    end else if ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F)) begin
      hex_val = 4'(char_code - CH_UPPER_A + 8'd10);
    end else if ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F)) begin
      hex_val = 4'(char_code - CH_LOWER_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    digit   = {28'd0, hex_val};
    acc_x10 = (st.acc << 3) + (st.acc << 1);
  end

  always_comb begin
    st_nxt = st;
    if (st.pos != 2'd3) begin
      st_nxt.pos = st.pos + 2'd1;
    end
    if (st.mode == MODE_ENDED) begin
      // token finished early, ignore the rest
    end else if (char_code == CH_NUL) begin
      if (st.mode == MODE_ESC) begin
        st_nxt.acc = VAL_BACKSLASH;
      end
      st_nxt.mode = MODE_ENDED;
    end else if ((st.mode == MODE_OCTN) && (st.pos == 2'd1) &&
                 ((char_code == CH_LOWER_X) || (char_code == CH_UPPER_X))) begin
      // hex prefix drops anything gathered so far
      st_nxt.mode    = MODE_HEX;
      st_nxt.acc     = '0;
      st_nxt.stopped = 1'b0;
    end else if (!st.stopped) begin
      unique case (st.mode)
        MODE_START: begin
          if (char_code == CH_QUOTE) begin
            st_nxt.mode = MODE_QUOTE;
          end else if ((char_code >= CH_ONE) && (char_code <= CH_NINE)) begin
            st_nxt.mode = MODE_DEC;
            st_nxt.acc  = digit;
          end else begin
            st_nxt.mode = MODE_OCTN;
            if (is_oct) st_nxt.acc = digit;
            else st_nxt.stopped = 1'b1;
          end
        end
        MODE_DEC: begin
          if (is_dec) st_nxt.acc = acc_x10 + digit;
          else st_nxt.stopped = 1'b1;
        end
        MODE_OCTN, MODE_OCTE: begin
          if (is_oct) st_nxt.acc = (st.acc << 3) + digit;
          else st_nxt.stopped = 1'b1;
        end
        MODE_HEX: begin
          if (is_hex) st_nxt.acc = (st.acc << 4) + digit;
          else st_nxt.stopped = 1'b1;
        end
        MODE_QUOTE: begin
          if (char_code == CH_BACKSLASH) begin
            st_nxt.mode = MODE_ESC;
          end else begin
            st_nxt.acc     = {24'd0, char_code};
            st_nxt.stopped = 1'b1;
          end
        end
        MODE_ESC: begin
          st_nxt.stopped = 1'b1;
          case (char_code)
            CH_LOWER_N: st_nxt.acc = VAL_NEWLINE;
            CH_LOWER_T: st_nxt.acc = VAL_TAB;
            CH_LOWER_V: st_nxt.acc = VAL_VTAB;
            CH_LOWER_R: st_nxt.acc = VAL_RETURN;
            CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BACKSLASH: st_nxt.acc = {24'd0, char_code};
            CH_LOWER_X: begin
              st_nxt.mode    = MODE_HEX;
              st_nxt.acc     = '0;
              st_nxt.stopped = 1'b0;
            end
            default: begin
              if (is_oct) begin
                st_nxt.mode    = MODE_OCTE;
                st_nxt.acc     = digit;
                st_nxt.stopped = 1'b0;
              end else begin
                st_nxt.acc = VAL_BACKSLASH;
              end
            end
          endcase
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
    // a token that ends right after the backslash reads as the backslash
    value = (st_nxt.mode == MODE_ESC) ? VAL_BACKSLASH : st_nxt.acc;
  end

endmodule

// ----- rtl/nlp_checker.sv -----
// port-level checker for the literal parser, bound to the top level
module nlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("token end without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("result without token end");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

endmodule

bind numeric_literal_parser_core nlp_checker u_nlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
